FILE: hw/rtl/kdl_pkg.sv
// Package for the keyed deque list: sizes, command and status codes,
// payload structs and the sequencer state type. No dependencies.
`default_nettype none
package kdl_pkg;
    localparam int CAPACITY = 32;
    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        FN_INSERT   = 3'd0,
        FN_DEL_KEY  = 3'd1,
        FN_DEL_HEAD = 3'd2,
        FN_DEL_TAIL = 3'd3,
        FN_DUMP     = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [31:0]       wdata;
        logic [PTR_W-1:0]  raddr;
    } mem_req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/kdl_ram.sv
// Key store: single write port, one registered read port.
// Depends on kdl_pkg.
`default_nettype none
module kdl_ram
    import kdl_pkg::*;
(
    input  wire logic        clk,
    input  wire mem_req_t    req,
    output logic [31:0]      rdata
);
    logic [31:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/kdl_ctrl.sv
// Command sequencer: scans, shifts and dumps the key store one entry a cycle.
// Depends on kdl_pkg.
`default_nettype none
module kdl_ctrl
    import kdl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire cmd_t   cmd,
    output logic        busy,
    output logic        done,
    output rsp_t        result,
    output mem_req_t    req,
    input  wire logic [31:0] rdata,
    output logic        head_wr,
    output logic [31:0] head_key
);
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;    // entry whose read is in flight; the hole in S_SHIFT_DN
    logic [31:0]       key_reg, key_next;
    logic              done_reg, done_next;
    rsp_t              res_reg, res_next;
    logic              accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    // next state and data path
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        req         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = cmd.key;
                    res_next = '{value: '0, status: ST_DONE, last: 1'b1};
                    case (cmd.func)
                        FN_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                                done_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                req.we = 1'b1;
                                req.wdata = cmd.key;
                                count_next = CNT_W'(1);
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // move entries up from the back
                                idx_next = count_reg - 1'b1;
                                req.raddr = PTR_W'(count_reg - 1'b1);
                                state_next = S_SHIFT_UP;
                            end
                        end
                        FN_DEL_KEY, FN_DEL_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NONE;
                                done_next = 1'b1;
                            end
                            else if (cmd.func == FN_DEL_HEAD)
                            begin
                                idx_next = '0;
                                req.raddr = PTR_W'(1);
                                state_next = S_SHIFT_DN;
                            end
                            else
                            begin
                                idx_next = '0;
                                req.raddr = '0;
                                state_next = S_SCAN;
                            end
                        end
                        FN_DEL_TAIL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NONE;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        FN_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next = '0;
                                req.raddr = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rdata == key_reg)
                begin
                    // shift the tail down over the match
                    req.raddr = PTR_W'(idx_reg + 1'b1);
                    state_next = S_SHIFT_DN;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    res_next.status = ST_NONE;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    req.raddr = PTR_W'(idx_reg + 1'b1);
                end
            end
            S_SHIFT_DN:
            begin
                // idx_reg is the hole; rdata holds entry idx+1 when in range
                if (idx_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    req.we = 1'b1;
                    req.waddr = PTR_W'(idx_reg);
                    req.wdata = rdata;
                    idx_next = idx_reg + 1'b1;
                    req.raddr = PTR_W'(idx_reg + 2'd2);
                end
            end
            S_SHIFT_UP:
            begin
                // the head write follows the move of entry 0
                req.we = 1'b1;
                req.waddr = PTR_W'(idx_reg + 1'b1);
                req.wdata = rdata;
                if (idx_reg == '0)
                begin
                    state_next = S_IDLE;
                    count_next = count_reg + 1'b1;
                    done_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    req.raddr = PTR_W'(idx_reg - 1'b1);
                end
            end
            S_DUMP:
            begin
                res_next = '{value: rdata, status: ST_DONE,
                             last: (idx_reg + 1'b1 == count_reg)};
                done_next = 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    req.raddr = PTR_W'(idx_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy     = (state_reg != S_IDLE) || done_reg;
        done     = done_reg;
        result   = res_reg;
        head_wr  = (state_reg == S_SHIFT_UP) && (idx_reg == '0);
        head_key = key_reg;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/kdl_head.sv
// Request merge: adds the head-entry write that closes an insert.
// Depends on kdl_pkg.
`default_nettype none
module kdl_head
    import kdl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req_in,
    input  wire logic     ins_fire,
    input  wire logic [31:0] ins_key,
    output mem_req_t      req_out,
    output logic          busy
);
    logic        pend_reg;
    logic [31:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ins_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= ins_key;
    end

    // place the new key at the front once the shift has finished
    always_comb
    begin
        req_out = req_in;
        if (pend_reg)
        begin
            req_out.we    = 1'b1;
            req_out.waddr = '0;
            req_out.wdata = key_reg;
        end
    end
    assign busy = pend_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/keyed_deque_list_core.sv
// Top level of the keyed deque list: sequencer, head-write merge, key RAM.
// Depends on kdl_pkg, kdl_ctrl, kdl_head, kdl_ram.
//
// Usage: drive cmd_in (func, key) with start; the command transfers at a rising
// edge where start is high and busy is low. Results appear on result with
// strobe high for one cycle each; the receiver cannot stall them.
// Each command walks the key RAM one entry a cycle; the steps per command:
//   delete back, full insert, edits and dump of an empty list: answered from idle;
//   insert: entries shifted up from the back, then head write;
//   delete by key: scan for the key, then shift the tail down over it if found;
//   delete front: shift down over entry 0; dump: one result per cycle.
// Commands 5 to 7 are dropped with no result.
// Reset clears the count, so the list is empty; no clearing pass is needed.
`default_nettype none
module keyed_deque_list_core
    import kdl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t cmd_in,
    output logic      busy,
    output logic      strobe,
    output rsp_t      result
);
    mem_req_t    ctrl_req, ram_req;
    logic [31:0] rdata;
    logic        ctrl_busy, head_busy, ins_fire;
    logic [31:0] ins_key;
    rsp_t        res;

    // insert that shifted entries finishes with a head write
    kdl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start && !head_busy), .cmd(cmd_in),
        .busy(ctrl_busy), .done(strobe), .result(res), .req(ctrl_req), .rdata(rdata),
        .head_wr(ins_fire), .head_key(ins_key)
    );

    kdl_head u_head (
        .clk(clk), .rst_n(rst_n), .req_in(ctrl_req), .ins_fire(ins_fire),
        .ins_key(ins_key), .req_out(ram_req), .busy(head_busy)
    );

    kdl_ram u_ram (.clk(clk), .req(ram_req), .rdata(rdata));

    assign busy   = ctrl_busy || head_busy;
    assign result = res;
endmodule
`default_nettype wire

FILE: hw/rtl/kdl_checker.sv
// Port-level checker for keyed_deque_list_core, bound to the top level.
// Depends on kdl_pkg.
`default_nettype none
module kdl_assertions
    import kdl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic strobe,
    input wire rsp_t result
);
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("strobe without busy");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != ST_DONE |-> result.value == 0 && result.last)
        else $error("status result malformed");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !strobe || busy) else $error("accept timing");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |=> !strobe) else $error("result after last");
endmodule

bind keyed_deque_list_core kdl_assertions u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(strobe), .result(result)
);
`default_nettype wire

FILE: dv/kdl_checker.sv
// Checker for the keyed deque list: watches command and result transfers,
// keeps its own list of keys and compares every result. Depends on kdl_pkg.
`timescale 1ns / 100ps
module kdl_checker
    import kdl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire cmd_t cmd_in,
    input  wire logic strobe,
    input  wire rsp_t result,
    output int        fail_count,
    output int        pending_count
);
    logic signed [31:0] list_keys[$];
    rsp_t               expected_rsps[$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input rsp_t got, input rsp_t exp);
        $display("%0t mismatch %s: got value=%0d status=%0d last=%0d, %s%0d %s%0d %s%0d",
                 $realtime, what, got.value, got.status, got.last,
                 "exp value=", exp.value, "status=", exp.status, "last=", exp.last);
        fail_count++;
    endtask

    function automatic rsp_t make_rsp(input logic signed [31:0] v, input status_t st,
                                      input logic lst);
        rsp_t r;
        r.value  = v;
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    // Apply one command to the list and queue the results it causes.
    task automatic apply_command(input cmd_t c);
        int     idx;
        logic   found;
        found = 1'b0;
        idx = 0;
        case (c.func)
            FN_INSERT:
            begin
                if (list_keys.size() >= CAPACITY)
                    expected_rsps.push_back(make_rsp(0, ST_FULL, 1'b1));
                else
                begin
                    list_keys.push_front(c.key);
                    expected_rsps.push_back(make_rsp(0, ST_DONE, 1'b1));
                end
            end
            FN_DEL_KEY:
            begin
                for (int i = 0; i < list_keys.size() && !found; i++)
                    if (list_keys[i] == c.key)
                    begin
                        found = 1'b1;
                        idx = i;
                    end
                if (found)
                    list_keys.delete(idx);
                expected_rsps.push_back(make_rsp(0, found ? ST_DONE : ST_NONE, 1'b1));
            end
            FN_DEL_HEAD, FN_DEL_TAIL:
            begin
                if (list_keys.size() == 0)
                    expected_rsps.push_back(make_rsp(0, ST_NONE, 1'b1));
                else
                begin
                    if (c.func == FN_DEL_HEAD)
                        void'(list_keys.pop_front());
                    else
                        void'(list_keys.pop_back());
                    expected_rsps.push_back(make_rsp(0, ST_DONE, 1'b1));
                end
            end
            FN_DUMP:
            begin
                if (list_keys.size() == 0)
                    expected_rsps.push_back(make_rsp(0, ST_EMPTY, 1'b1));
                else
                    foreach (list_keys[i])
                        expected_rsps.push_back(make_rsp(list_keys[i], ST_DONE,
                                                         i == list_keys.size() - 1));
            end
            default:
            begin
                // unused codes: drop
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        rsp_t exp;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected result", result, '0);
                else
                begin
                    exp = expected_rsps.pop_front();
                    if (result.value !== exp.value)
                        report_mismatch("value", result, exp);
                    else if (result.status !== exp.status)
                        report_mismatch("status", result, exp);
                    else if (result.last !== exp.last)
                        report_mismatch("last", result, exp);
                end
            end
            if (start && !busy)
                apply_command(cmd_in);
        end
        pending_count = expected_rsps.size();
    end
endmodule

FILE: dv/tb_keyed_deque_list_core.sv
// Testbench top for keyed_deque_list_core: drives directed and random commands
// with random gaps and gives the verdict. Depends on kdl_pkg and kdl_checker.
`timescale 1ns / 100ps
module tb_keyed_deque_list_core;
    import kdl_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd_in;
    logic busy;
    logic strobe;
    rsp_t result;
    int   fail_count;
    int   pending_count;

    logic signed [31:0] used_keys[$];

    keyed_deque_list_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd_in (cmd_in),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    kdl_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd_in        (cmd_in),
        .strobe        (strobe),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Hold start until the transfer, then add a random gap.
    task automatic send_cmd(input logic [2:0] f, input logic signed [31:0] k);
        int gap;
        start  <= 1'b1;
        cmd_in <= '{func: f, key: k};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd_in <= '{func: 3'($urandom), key: $urandom};
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || busy)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key;
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
    endfunction

    initial
    begin
        logic [2:0]         f;
        logic signed [31:0] k;
        int                 sel;
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd_in = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-list edits and dump, then extreme and duplicate inserts, key deletes, unused codes
        send_cmd(FN_DUMP, 0);
        send_cmd(FN_DEL_HEAD, 0);
        send_cmd(FN_DEL_TAIL, 0);
        send_cmd(FN_DEL_KEY, 5);
        send_cmd(FN_INSERT, 32'sh7FFF_FFFF);
        send_cmd(FN_INSERT, 32'sh8000_0000);
        send_cmd(FN_INSERT, -1);
        send_cmd(FN_INSERT, -1);
        send_cmd(FN_DUMP, 0);
        send_cmd(FN_DEL_KEY, -1);
        send_cmd(FN_DEL_KEY, 12345);
        send_cmd(3'd5, 1);
        send_cmd(3'd6, 2);
        send_cmd(3'd7, -1);
        send_cmd(FN_DEL_TAIL, 0);
        send_cmd(FN_DEL_HEAD, 0);
        send_cmd(FN_DUMP, 0);
        drain();

        // fill past capacity, dump, then delete one key 7
        for (int i = 0; i < CAPACITY + 2; i++)
            send_cmd(FN_INSERT, (i % 3 == 0) ? 7 : $urandom);
        send_cmd(FN_DUMP, 0);
        send_cmd(FN_DEL_KEY, 7);
        drain();

        for (int n = 0; n < 170; n++)
        begin
            sel = $urandom_range(0, 99);
            k = pick_key();
            if (sel < 40)
            begin
                f = FN_INSERT;
                used_keys.push_back(k);
                if (used_keys.size() > 16)
                    void'(used_keys.pop_front());
            end
            else if (sel < 60)
                f = FN_DEL_KEY;
            else if (sel < 72)
                f = FN_DEL_HEAD;
            else if (sel < 84)
                f = FN_DEL_TAIL;
            else if (sel < 96)
                f = FN_DUMP;
            else
                f = 3'($urandom_range(5, 7));
            send_cmd(f, k);
            if (n == 85)
                drain();
        end
        drain();

        if (fail_count == 0)
            $display("** keyed_deque_list_core: PASSED **");
        else
            $display("** keyed_deque_list_core: FAILED **");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("** keyed_deque_list_core: FAILED **");
        $finish;
    end
endmodule
